// ===== rtl/cfdr_pkg.sv =====
// Shared types and constants for the CAN frame deframer with byte ring.
// Used by cfdr_ring and can_frame_deframer_ring; no dependencies.
package cfdr_pkg;

	localparam int unsigned ID_W      = 11;
	localparam int unsigned LEN_W     = 4;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned NBYTES    = 8;
	localparam int unsigned CNT_W     = 3;
	localparam int unsigned HDR_W     = 32;
	localparam int unsigned CFG_W     = 32;
	localparam int unsigned ADDR_W    = 3;
	localparam int unsigned S_DATA_W  = 80;
	localparam int unsigned M_DATA_W  = 24;
	localparam int unsigned STATUS_W  = 4;

	localparam logic [ID_W-1:0]   OWN_ID_RST = 11'h711;
	localparam logic [HDR_W-1:0]  HEADER_RST = 32'hAABBCCDD;
	localparam logic [LEN_W-1:0]  LEN_MAX    = 4'd8;
	localparam logic [LEN_W-1:0]  LEN_HEADER = 4'd5;

	localparam logic REG_OWN_ID = 1'b0;
	localparam logic REG_HEADER = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_STORED     = 4'd0,
		ST_ANNOUNCED  = 4'd1,
		ST_NO_SPACE   = 4'd2,
		ST_TOO_LONG   = 4'd3,
		ST_BAD_HEADER = 4'd4,
		ST_UNKNOWN    = 4'd5,
		ST_OTHER_ID   = 4'd6,
		ST_READ       = 4'd7,
		ST_EMPTY      = 4'd8
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EVAL   = 5'b00010,
		S_STORE  = 5'b00100,
		S_RDWAIT = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

endpackage

// ===== rtl/cfdr_ring.sv =====
// Byte ring storage: one write port and one registered read port.
// Depends on cfdr_pkg for the byte width.
module cfdr_ring #(
	parameter int unsigned DEPTH = 4096
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [cfdr_pkg::BYTE_W-1:0]      wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [cfdr_pkg::BYTE_W-1:0]      rdata
);

	logic [cfdr_pkg::BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/can_frame_deframer_ring.sv =====
// Top level of the CAN frame deframer: sequencer, pointers, APB registers.
// Depends on cfdr_pkg and instantiates cfdr_ring.
//
// Usage: the slave stream carries one item per transfer; s_tuser[0] selects
// a received CAN frame (0) or a pop of one byte from the ring (1). Frames
// with a matching identifier either announce a payload length (five-byte
// header frame) or deposit their data bytes into the ring while the announced
// count lasts. The master stream returns exactly one result per item.
// Flow: an item is taken only while the sequencer is idle, so a new item is not
// accepted before the last one is through. A frame passes the evaluate state,
// a store state for each data byte, set by the single ring write port used once
// per byte, and the done state. A pop passes the evaluate state, a read-wait
// state for the registered ring read, and the done state; a pop of an empty
// ring skips the read-wait state.
// The output register lets the next item be accepted while a result waits;
// if the receiver stalls, the following item finishes its work and then holds
// until the output register is free.
// Reset: write pointer and counts clear, read pointer sets to all ones, own_id
// and header_word take defaults, ring contents undefined. No clearing pass is needed.
// Configuration: APB, own_id at address 0, header_word at address 4.
module can_frame_deframer_ring #(
	parameter int unsigned RING_DEPTH = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// s_tdata: frame_id, frame_len, data_byte_0 .. data_byte_7, zero pad
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [cfdr_pkg::S_DATA_W-1:0]     s_tdata,
	// s_tuser: action
	input  logic                              s_tuser,
	// m_tdata: read_byte, data_available, pending_payload, zero pad
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [cfdr_pkg::M_DATA_W-1:0]     m_tdata,
	// m_tuser: status
	output logic [cfdr_pkg::STATUS_W-1:0]     m_tuser,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cfdr_pkg::ADDR_W-1:0]       paddr,
	input  logic [cfdr_pkg::CFG_W-1:0]        pwdata,
	output logic [cfdr_pkg::CFG_W-1:0]        prdata,
	output logic                              pready
);

	localparam int unsigned PTR_W = $clog2(RING_DEPTH);
	localparam int unsigned CMP_W = (PTR_W > cfdr_pkg::BYTE_W) ? PTR_W : cfdr_pkg::BYTE_W;

	cfdr_pkg::state_t                 state_q;
	cfdr_pkg::status_t                status_q;
	logic [cfdr_pkg::ID_W-1:0]        own_id_q;
	logic [cfdr_pkg::HDR_W-1:0]       header_q;
	logic                             act_q;
	logic [cfdr_pkg::ID_W-1:0]        id_q;
	logic [cfdr_pkg::LEN_W-1:0]       len_q;
	logic [cfdr_pkg::BYTE_W-1:0]      bytes_q [cfdr_pkg::NBYTES];
	logic [cfdr_pkg::CNT_W-1:0]       cnt_q;
	logic [PTR_W-1:0]                 wr_q;
	logic [PTR_W-1:0]                 rd_q;
	logic [cfdr_pkg::BYTE_W-1:0]      exp_q;
	logic                             m_tvalid_q;
	logic [cfdr_pkg::M_DATA_W-1:0]    m_tdata_q;
	logic [cfdr_pkg::STATUS_W-1:0]    m_tuser_q;

	logic [cfdr_pkg::LEN_W-1:0]       in_len;
	logic [cfdr_pkg::BYTE_W-1:0]      rdata;
	logic [PTR_W-1:0]                 rd_next;
	logic                             ring_empty;
	logic [PTR_W-1:0]                 free_cnt;
	logic                             hdr_ok;
	logic                             space_ok;
	logic                             store_last;
	logic                             out_free;
	logic [cfdr_pkg::BYTE_W-1:0]      out_byte;
	logic                             cfg_we;

	assign s_tready = (state_q == cfdr_pkg::S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign pready   = 1'b1;

	assign in_len = (s_tdata[14:11] > cfdr_pkg::LEN_MAX) ? cfdr_pkg::LEN_MAX : s_tdata[14:11];

	assign rd_next    = rd_q + 1'b1;
	assign ring_empty = (wr_q == rd_next);
	assign free_cnt   = rd_q - wr_q;
	assign hdr_ok     = (bytes_q[0] == header_q[31:24]) && (bytes_q[1] == header_q[23:16])
			&& (bytes_q[2] == header_q[15:8]) && (bytes_q[3] == header_q[7:0]);
	assign space_ok   = (CMP_W'(free_cnt) >= CMP_W'(bytes_q[4]));
	assign store_last = (({1'b0, cnt_q} + 1'b1) == len_q);
	assign out_free   = !m_tvalid_q || m_tready;
	assign out_byte   = (status_q == cfdr_pkg::ST_READ) ? rdata : '0;

	assign cfg_we = psel && penable && pwrite;
	assign prdata = (paddr[2] == cfdr_pkg::REG_HEADER) ? header_q
			: {{(cfdr_pkg::CFG_W - cfdr_pkg::ID_W){1'b0}}, own_id_q};

	cfdr_ring #(
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (state_q == cfdr_pkg::S_STORE),
		.waddr (wr_q),
		.wdata (bytes_q[cnt_q]),
		.raddr (rd_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= cfdr_pkg::OWN_ID_RST;
			header_q <= cfdr_pkg::HEADER_RST;
		end else if (cfg_we) begin
			if (paddr[2] == cfdr_pkg::REG_HEADER) begin
				header_q <= pwdata;
			end else begin
				own_id_q <= pwdata[cfdr_pkg::ID_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_q <= s_tuser;
			id_q  <= s_tdata[10:0];
			len_q <= in_len;
			for (int i = 0; i < cfdr_pkg::NBYTES; i++) begin
				bytes_q[i] <= s_tdata[15 + 8*i +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cfdr_pkg::S_IDLE;
			status_q   <= cfdr_pkg::ST_STORED;
			cnt_q      <= '0;
			wr_q       <= '0;
			rd_q       <= '1;
			exp_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != cfdr_pkg::S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				cfdr_pkg::S_IDLE: begin
					if (s_tvalid) begin
						state_q <= cfdr_pkg::S_EVAL;
					end
				end
				cfdr_pkg::S_EVAL: begin
					cnt_q   <= '0;
					state_q <= cfdr_pkg::S_DONE;
					if (act_q) begin
						if (ring_empty) begin
							status_q <= cfdr_pkg::ST_EMPTY;
						end else begin
							rd_q     <= rd_next;
							status_q <= cfdr_pkg::ST_READ;
							state_q  <= cfdr_pkg::S_RDWAIT;
						end
					end else if (id_q != own_id_q) begin
						status_q <= cfdr_pkg::ST_OTHER_ID;
					end else if (exp_q != '0) begin
						if ({4'd0, len_q} <= exp_q) begin
							exp_q    <= exp_q - {4'd0, len_q};
							status_q <= cfdr_pkg::ST_STORED;
							if (len_q != '0) begin
								state_q <= cfdr_pkg::S_STORE;
							end
						end else begin
							exp_q    <= '0;
							status_q <= cfdr_pkg::ST_TOO_LONG;
						end
					end else if (len_q != cfdr_pkg::LEN_HEADER) begin
						status_q <= cfdr_pkg::ST_UNKNOWN;
					end else if (!hdr_ok) begin
						status_q <= cfdr_pkg::ST_BAD_HEADER;
					end else if (space_ok) begin
						exp_q    <= bytes_q[4];
						status_q <= cfdr_pkg::ST_ANNOUNCED;
					end else begin
						status_q <= cfdr_pkg::ST_NO_SPACE;
					end
				end
				cfdr_pkg::S_STORE: begin
					wr_q  <= wr_q + 1'b1;
					cnt_q <= cnt_q + 1'b1;
					if (store_last) begin
						state_q <= cfdr_pkg::S_DONE;
					end
				end
				cfdr_pkg::S_RDWAIT: begin
					state_q <= cfdr_pkg::S_DONE;
				end
				cfdr_pkg::S_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= status_q;
						m_tdata_q  <= {7'd0, exp_q, !ring_empty, out_byte};
						state_q    <= cfdr_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= cfdr_pkg::S_IDLE;
				end
			endcase
		end
	end

endmodule
